FILE: rtl/core/sorted_integer_set_core_assert.svh
// Assertion macros for the sorted integer set core checker.
// Expects clk and arst_n in the scope of each use.
`ifndef SORTED_INTEGER_SET_CORE_ASSERT_SVH
`define SORTED_INTEGER_SET_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent (or after an explicit delay).
`define SIS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("sorted set core: property violated");

// Consequent checked in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("sorted set core: property violated");

`endif

FILE: rtl/core/sis_pkg.sv
// Shared types and codes for the sorted integer set core.
// No dependencies; used by the cell, the top level and the checker.
package sis_pkg;

	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 5;
	localparam int CAPACITY_DEF = 16;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_CHANGED = 2'd0;
	localparam logic [1:0] ST_SAME    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [VALUE_W-1:0] value;
	} sis_req_t;

	typedef struct packed {
		logic               was_present;
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
	} sis_rsp_t;

	// Control from the top level to every cell
	typedef struct packed {
		logic cmp_en;
		logic ins;
		logic rem;
	} sis_ctrl_t;

	// Compare flags held in each cell between compare and update
	typedef struct packed {
		logic eq;
		logic ge;
	} sis_flag_t;

endpackage

FILE: rtl/core/sis_cell.sv
// One cell of the sorted set chain: holds a single element and its compare flags.
// Depends on sis_pkg.
module sis_cell import sis_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic                      clk,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [CNT_W-1:0]          cnt,
	input  sis_ctrl_t                 ctrl,
	input  logic signed [VALUE_W-1:0] left_elem,
	input  logic                      left_ge,
	input  logic signed [VALUE_W-1:0] right_elem,
	output logic signed [VALUE_W-1:0] elem,
	output sis_flag_t                 flag
);

	logic signed [VALUE_W-1:0] elem_q;
	sis_flag_t                 flag_q;
	logic                      occ;

	// Cell is occupied while its position lies below the fill count
	assign occ = (cnt > CNT_W'(INDEX));

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			flag_q.eq <= occ && (elem_q == value);
			// free cells rank above every value
			flag_q.ge <= !occ || (elem_q > value);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && flag_q.ge) begin
			// first cell at or past the insertion point takes the value, the rest shift up
			elem_q <= left_ge ? left_elem : value;
		end else if (ctrl.rem && (flag_q.ge || flag_q.eq)) begin
			elem_q <= right_elem;
		end
	end

	assign elem = elem_q;
	assign flag = flag_q;

endmodule

FILE: rtl/core/sorted_integer_set_core.sv
// Sorted integer set core: a chain of CAPACITY cells kept in ascending order.
// An accepted item passes the compare stage (cmp_q) and the update stage (upd_q); done strobes
// its result. Every cell registers its compare flags before the presence reduction and the shift
// through the chain; busy covers the compare stage, so a new item may enter during the update.
// Reset clears the fill count and the control flags; cell contents stay undefined until written.
module sorted_integer_set_core import sis_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sis_req_t req,
	output logic     done,
	output sis_rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                      cmp_q;
	logic                      upd_q;
	logic                      done_q;
	logic [1:0]                op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          cnt_nxt;
	sis_rsp_t                  rsp_q;
	sis_ctrl_t                 ctrl;

	logic signed [VALUE_W-1:0] elem_w [CAPACITY];
	sis_flag_t                 flag_w [CAPACITY];
	logic [CAPACITY-1:0]       eq_vec;

	logic                      present;
	logic                      full;
	logic                      accept;
	logic [1:0]                status;
	logic [CNT_W+COUNT_W-1:0]  cnt_wide;

	assign accept = start && !busy;
	assign busy   = cmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q  <= 1'b0;
			upd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			cmp_q  <= accept;
			upd_q  <= cmp_q;
			done_q <= upd_q;
			if (upd_q) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			value_q <= req.value;
		end
		if (upd_q) begin
			rsp_q.was_present <= present;
			rsp_q.status      <= status;
			rsp_q.count       <= cnt_wide[COUNT_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			eq_vec[i] = flag_w[i].eq;
		end
	end

	assign present = |eq_vec;
	assign full    = (cnt_q == CNT_W'(CAPACITY));

	always_comb begin
		ctrl.cmp_en = cmp_q;
		ctrl.ins    = 1'b0;
		ctrl.rem    = 1'b0;
		status      = ST_SAME;
		cnt_nxt     = cnt_q;
		case (op_q)
			OP_ADD: begin
				if (!present) begin
					if (full) begin
						status = ST_FULL;
					end else begin
						ctrl.ins = upd_q;
						status   = ST_CHANGED;
						cnt_nxt  = cnt_q + CNT_W'(1);
					end
				end
			end
			OP_REMOVE: begin
				if (present) begin
					ctrl.rem = upd_q;
					status   = ST_CHANGED;
					cnt_nxt  = cnt_q - CNT_W'(1);
				end
			end
			OP_QUERY: begin
				status = ST_SAME;
			end
			default: begin
				status = ST_SAME;
			end
		endcase
	end

	assign cnt_wide = {{COUNT_W{1'b0}}, cnt_nxt};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VALUE_W-1:0] left_elem;
		logic                      left_ge;
		logic signed [VALUE_W-1:0] right_elem;

		if (g == 0) begin : g_head
			assign left_elem = value_q;
			assign left_ge   = 1'b0;
		end else begin : g_body
			assign left_elem = elem_w[g-1];
			assign left_ge   = flag_w[g-1].ge;
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign right_elem = elem_w[g];
		end else begin : g_mid
			assign right_elem = elem_w[g+1];
		end

		sis_cell #(
			.INDEX (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.value      (value_q),
			.cnt        (cnt_q),
			.ctrl       (ctrl),
			.left_elem  (left_elem),
			.left_ge    (left_ge),
			.right_elem (right_elem),
			.elem       (elem_w[g]),
			.flag       (flag_w[g])
		);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/core/sis_chk.sv
// Port-level checker for the sorted integer set core, bound to the top level.
// Depends on sis_pkg and sorted_integer_set_core_assert.svh.
`include "sorted_integer_set_core_assert.svh"

module sis_chk import sis_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input sis_req_t req,
	input logic     done,
	input sis_rsp_t rsp
);

	logic accept;

	assign accept = start && !busy;

	`SIS_ASSERT_NEXT(a_busy_after_accept, accept, busy)
	`SIS_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
	`SIS_ASSERT_SAME(a_result_after_three, accept, ##3 done)
	`SIS_ASSERT_SAME(a_full_means_absent, done && (rsp.status == ST_FULL), !rsp.was_present)
	`SIS_ASSERT_SAME(a_status_code, done, rsp.status <= ST_FULL)

endmodule

bind sorted_integer_set_core sis_chk #(.CAPACITY(CAPACITY)) u_sis_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
